/* sv/n2a_pkg.sv */
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, codes and helpers of the number to ascii formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package n2a_pkg;

    localparam logic [1:0] RADIX_HEX = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam int VALUE_W  = 32;
    localparam int DIGITS_W = 4;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W    = DEC_DIGITS * DIGITS_W;
    localparam int COUNT_W  = 6;
    localparam int ITER_W   = 5;

    localparam logic [COUNT_W-1:0] HEX_CHARS = 6'd8;
    localparam logic [COUNT_W-1:0] DEC_CHARS = 6'd10;
    localparam logic [COUNT_W-1:0] BIN_CHARS = 6'd32;

    localparam logic [ITER_W-1:0] LAST_ITER = 5'd31;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_A    = 8'h61;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         radix_mode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic start;
    } t_conv_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10) begin
            hex_char = CHAR_ZERO + wide;
        end else begin
            hex_char = CHAR_A + wide - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/n2a_dabble.sv */
// ----------------------------------------------------------------------------
// n2a_dabble
// Iterative binary to bcd converter, one shift and add-three step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_dabble (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire n2a_pkg::t_conv_ctl            i_ctl,
    input  wire logic [n2a_pkg::VALUE_W-1:0]   i_value,
    output n2a_pkg::t_conv_sts                 o_sts,
    output logic      [n2a_pkg::BCD_W-1:0]     o_bcd
);

    logic [n2a_pkg::VALUE_W-1:0] r_bin;
    logic [n2a_pkg::BCD_W-1:0]   r_bcd;
    logic [n2a_pkg::ITER_W-1:0]  r_iter;
    logic                        r_busy;
    logic                        r_done;
    logic [n2a_pkg::BCD_W-1:0]   adj;

    // add three to every digit above four
    always_comb begin
        for (int d = 0; d < n2a_pkg::DEC_DIGITS; d++) begin
            if (r_bcd[d*n2a_pkg::DIGITS_W +: n2a_pkg::DIGITS_W] > 4'd4) begin
                adj[d*n2a_pkg::DIGITS_W +: n2a_pkg::DIGITS_W] =
                    r_bcd[d*n2a_pkg::DIGITS_W +: n2a_pkg::DIGITS_W] + 4'd3;
            end else begin
                adj[d*n2a_pkg::DIGITS_W +: n2a_pkg::DIGITS_W] =
                    r_bcd[d*n2a_pkg::DIGITS_W +: n2a_pkg::DIGITS_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_bin  <= i_value;
                r_bcd  <= '0;
                r_iter <= n2a_pkg::LAST_ITER;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_bin <= {r_bin[n2a_pkg::VALUE_W-2:0], 1'b0};
                r_bcd <= {adj[n2a_pkg::BCD_W-2:0], r_bin[n2a_pkg::VALUE_W-1]};
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter - 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_bcd      = r_bcd;

endmodule

`default_nettype wire

/* sv/number_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats a 32-bit unsigned number as ascii digits in hex, decimal or binary.
// ----------------------------------------------------------------------------
// usage: an input transaction carries value and radix_mode; the block then
// sends one output transaction per character, most significant first, with
// last set on the final one. hex gives eight lower-case digits, binary 32
// characters, decimal one to ten digits without leading zeros. radix code 3
// is taken and gives no output.
// the block works on one number at a time and stalls its input until the
// final character has entered the output register. hex and binary emit one
// character per cycle from a shift register while the output is not stalled.
// decimal first runs the iterative bcd converter, one bit per cycle, then
// drops leading zeros one digit per cycle and emits the digits (1 to 10).
// in hex or binary the first character comes straight from the accepted
// value; in decimal it follows the conversion and the leading-zero skip.
// an output stall holds the output register and pauses emission; no
// character is lost. reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_ascii_formatter (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire n2a_pkg::t_in_item    i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output n2a_pkg::t_out_item        o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                        r_state, n_state;
    logic [n2a_pkg::BCD_W-1:0]     r_work, n_work;
    logic [n2a_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [1:0]                    r_mode, n_mode;
    logic                          r_out_valid, n_out_valid;
    n2a_pkg::t_out_item            r_out, n_out;

    n2a_pkg::t_conv_ctl            conv_ctl;
    n2a_pkg::t_conv_sts            conv_sts;
    logic [n2a_pkg::BCD_W-1:0]     conv_bcd;
    logic                          in_take;
    logic                          out_free;
    logic [7:0]                    cur_char;

    n2a_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (conv_ctl),
        .i_value (i_in_item.value),
        .o_sts   (conv_sts),
        .o_bcd   (conv_bcd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign conv_ctl.start = in_take && (i_in_item.radix_mode == n2a_pkg::RADIX_DEC);

    always_comb begin
        case (r_mode)
            n2a_pkg::RADIX_HEX: cur_char = n2a_pkg::hex_char(r_work[31:28]);
            n2a_pkg::RADIX_BIN: cur_char = r_work[31] ? n2a_pkg::CHAR_ONE
                                                      : n2a_pkg::CHAR_ZERO;
            default:            cur_char = n2a_pkg::CHAR_ZERO
                                           + {4'b0000, r_work[39:36]};
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_count     = r_count;
        n_mode      = r_mode;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_mode = i_in_item.radix_mode;
                    n_work = {8'h00, i_in_item.value};
                    case (i_in_item.radix_mode)
                        n2a_pkg::RADIX_HEX: begin
                            n_count = n2a_pkg::HEX_CHARS;
                            n_state = S_EMIT;
                        end
                        n2a_pkg::RADIX_DEC: begin
                            n_state = S_CONV;
                        end
                        n2a_pkg::RADIX_BIN: begin
                            n_count = n2a_pkg::BIN_CHARS;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (conv_sts.done) begin
                    n_work  = conv_bcd;
                    n_count = n2a_pkg::DEC_CHARS;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_work[39:36] == 4'd0 && r_count != 6'd1) begin
                    n_work  = {r_work[35:0], 4'h0};
                    n_count = r_count - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.ascii_char = cur_char;
                    n_out.last       = (r_count == 6'd1);
                    n_count          = r_count - 1'b1;
                    if (r_mode == n2a_pkg::RADIX_BIN) begin
                        n_work = {r_work[38:0], 1'b0};
                    end else begin
                        n_work = {r_work[35:0], 4'h0};
                    end
                    if (r_count == 6'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        r_work <= n_work;
        r_mode <= n_mode;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
